### hdl/tnrx_pkg.sv
`timescale 1ns / 1ps
package tnrx_pkg;

	localparam int OPTION_COUNT_DEF = 256;
	localparam int JOBQ_DEPTH_DEF   = 4;

	// request types
	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_OPEN   = 2'd1;
	localparam logic [1:0] REQ_RESET  = 2'd2;
	localparam logic [1:0] REQ_RESIZE = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_SEND = 2'd1;
	localparam logic [1:0] KIND_GA   = 2'd2;
	localparam logic [1:0] KIND_ECHO = 2'd3;

	// telnet commands
	localparam logic [7:0] C_SE   = 8'd240;
	localparam logic [7:0] C_AYT  = 8'd246;
	localparam logic [7:0] C_GA   = 8'd249;
	localparam logic [7:0] C_SB   = 8'd250;
	localparam logic [7:0] C_WILL = 8'd251;
	localparam logic [7:0] C_WONT = 8'd252;
	localparam logic [7:0] C_DO   = 8'd253;
	localparam logic [7:0] C_DONT = 8'd254;
	localparam logic [7:0] C_IAC  = 8'd255;
	localparam logic [7:0] C_BEL  = 8'd7;

	// options
	localparam logic [7:0] O_ECHO    = 8'd1;
	localparam logic [7:0] O_SGA     = 8'd3;
	localparam logic [7:0] O_STATUS  = 8'd5;
	localparam logic [7:0] O_TM      = 8'd6;
	localparam logic [7:0] O_TTYPE   = 8'd24;
	localparam logic [7:0] O_NAWS    = 8'd31;
	localparam logic [7:0] O_CHARSET = 8'd42;

	// job segments, emitted lowest bit first
	localparam int SEG_DATA = 0;
	localparam int SEG_OPT  = 1;
	localparam int SEG_ECHO = 2;
	localparam int SEG_AYT  = 3;
	localparam int SEG_GA   = 4;
	localparam int SEG_NAWS = 5;
	localparam int SEG_N    = 6;

	localparam int AYT_LEN = 35;
	localparam logic [AYT_LEN*8-1:0] AYT_STR = "I'm here! Please be more patient!\015\012";

	// NAWS report slots: IAC SB 31, four size bytes each with a doubling slot, IAC SE
	localparam logic [5:0] NAWS_LAST = 6'd12;
	localparam logic [5:0] OPT_LAST  = 6'd2;
	localparam logic [5:0] AYT_LAST  = 6'(AYT_LEN - 1);

	typedef struct packed {
		logic [SEG_N-1:0] segs;
		logic [7:0]       data;
		logic [7:0]       verb;
		logic [7:0]       opt;
		logic             echo_val;
		logic [15:0]      cols;
		logic [15:0]      rows;
	} job_t;

	function automatic logic remote_sup(input logic [7:0] o);
		return o == O_SGA || o == O_STATUS || o == O_TTYPE || o == O_NAWS ||
			o == O_ECHO || o == O_CHARSET;
	endfunction

	function automatic logic local_sup(input logic [7:0] o);
		return o == O_SGA || o == O_STATUS || o == O_TTYPE || o == O_NAWS ||
			o == O_CHARSET;
	endfunction

	function automatic logic [7:0] ayt_char(input logic [5:0] idx);
		logic [5:0] pos;
		pos = 6'(AYT_LEN - 1) - idx;
		return AYT_STR[pos*8 +: 8];
	endfunction

	function automatic logic [7:0] naws_byte(input logic [5:0] idx,
		input logic [15:0] cols, input logic [15:0] rows);
		logic [7:0] b;
		b = 8'd0;
		unique case (idx)
			6'd0, 6'd11: b = C_IAC;
			6'd1:        b = C_SB;
			6'd2:        b = O_NAWS;
			6'd3, 6'd4:  b = cols[15:8];
			6'd5, 6'd6:  b = cols[7:0];
			6'd7, 6'd8:  b = rows[15:8];
			6'd9, 6'd10: b = rows[7:0];
			6'd12:       b = C_SE;
			default:     b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

### hdl/tnrx_front.sv
`timescale 1ns / 1ps
module tnrx_front #(
	parameter int OPTION_COUNT = tnrx_pkg::OPTION_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic [7:0]         rx_byte,
	input  logic [15:0]        win_cols,
	input  logic [15:0]        win_rows,
	input  logic               q_full,
	output logic               job_push,
	output tnrx_pkg::job_t     job
);
	import tnrx_pkg::*;

	localparam int OIW = $clog2(OPTION_COUNT);

	localparam logic [2:0] M_NORMAL = 3'd0;
	localparam logic [2:0] M_IAC    = 3'd1;
	localparam logic [2:0] M_VERB   = 3'd2;
	localparam logic [2:0] M_SB     = 3'd3;
	localparam logic [2:0] M_SB_IAC = 3'd4;

	// bits of one option map entry
	localparam int MB_LE = 3;
	localparam int MB_RE = 2;
	localparam int MB_LA = 1;
	localparam int MB_RA = 0;

	logic [3:0]              map_q [OPTION_COUNT];
	logic [OPTION_COUNT-1:0] vld_q;
	logic [3:0]  ent_s1;
	logic        ent_vld_s1;
	logic        valid_s1;
	logic [1:0]  req_s1;
	logic [7:0]  byte_s1;
	logic [15:0] wcols_s1, wrows_s1;
	logic [2:0]  mode_s1;
	logic [7:0]  verb_s1;
	logic [2:0]  mode_q, mode_d;
	logic [7:0]  verb_q, verb_d;
	logic [15:0] cols_q, cols_d, rows_q, rows_d;
	logic        naws_le_q, naws_le_d;
	logic [3:0]  ent, ent_d;
	logic        ent_wr, clr_all;
	logic        accept, move;
	logic [OIW-1:0] rd_a, wr_a;

	assign rd_a = OIW'(rx_byte);
	assign wr_a = OIW'(byte_s1);

	// parser mode advances at accept; map lookups are used in the registered s1 stage
	always_comb begin
		mode_d = mode_q;
		verb_d = verb_q;
		if (accept) begin
			unique case (req_type)
				REQ_BYTE: begin
					unique case (mode_q)
						M_IAC: begin
							if (rx_byte == C_WILL || rx_byte == C_WONT ||
								rx_byte == C_DO || rx_byte == C_DONT) begin
								verb_d = rx_byte;
								mode_d = M_VERB;
							end else if (rx_byte == C_SB) begin
								mode_d = M_SB;
							end else begin
								mode_d = M_NORMAL;
							end
						end
						M_VERB: begin
							mode_d = M_NORMAL;
						end
						M_SB: begin
							if (rx_byte == C_IAC) mode_d = M_SB_IAC;
						end
						M_SB_IAC: begin
							mode_d = (rx_byte == C_SE) ? M_NORMAL : M_SB;
						end
						default: begin
							mode_d = (rx_byte == C_IAC) ? M_IAC : M_NORMAL;
						end
					endcase
				end
				REQ_RESET: begin
					mode_d = M_NORMAL;
					verb_d = 8'd0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		ent = ent_vld_s1 ? ent_s1 : 4'd0;
		ent_d = ent;
		ent_wr = 1'b0;
		clr_all = 1'b0;
		cols_d = cols_q;
		rows_d = rows_q;
		naws_le_d = naws_le_q;
		job = '0;
		job.cols = cols_q;
		job.rows = rows_q;
		if (valid_s1) begin
			unique case (req_s1)
				REQ_BYTE: begin
					unique case (mode_s1)
						M_IAC: begin
							if (byte_s1 == C_IAC) begin
								job.segs[SEG_DATA] = 1'b1;
								job.data = byte_s1;
							end else begin
								job.segs[SEG_AYT] = (byte_s1 == C_AYT);
								job.segs[SEG_GA]  = (byte_s1 == C_GA);
							end
						end
						M_VERB: begin
							job.opt = byte_s1;
							ent_wr = 1'b1;
							if (verb_s1 == C_WILL) begin
								ent_d[MB_RA] = 1'b1;
								if (!ent[MB_RE]) begin
									job.segs[SEG_OPT] = 1'b1;
									if (remote_sup(byte_s1)) begin
										job.verb = C_DO;
										ent_d[MB_RE] = 1'b1;
										job.segs[SEG_ECHO] = (byte_s1 == O_ECHO);
									end else begin
										job.verb = C_DONT;
									end
								end
							end else if (verb_s1 == C_WONT) begin
								if (ent[MB_RE] || !ent[MB_RA]) begin
									job.segs[SEG_OPT] = 1'b1;
									job.verb = C_DONT;
									ent_d[MB_RE] = 1'b0;
									job.segs[SEG_ECHO] = (byte_s1 == O_ECHO);
									job.echo_val = 1'b1;
								end
								ent_d[MB_RA] = 1'b1;
							end else if (verb_s1 == C_DO) begin
								if (byte_s1 == O_TM) begin
									job.segs[SEG_OPT] = 1'b1;
									job.verb = C_WILL;
								end else if (!ent[MB_LE]) begin
									job.segs[SEG_OPT] = 1'b1;
									if (local_sup(byte_s1)) begin
										job.verb = C_WILL;
										ent_d[MB_LE] = 1'b1;
									end else begin
										job.verb = C_WONT;
									end
									ent_d[MB_LA] = 1'b1;
								end
								// DO NAWS always leaves NAWS enabled
								job.segs[SEG_NAWS] = (byte_s1 == O_NAWS);
							end else if (verb_s1 == C_DONT) begin
								if (ent[MB_LE] || !ent[MB_LA]) begin
									job.segs[SEG_OPT] = 1'b1;
									job.verb = C_WONT;
									ent_d[MB_LA] = 1'b1;
								end
								ent_d[MB_LE] = 1'b0;
							end
							if (byte_s1 == O_NAWS) naws_le_d = ent_d[MB_LE];
						end
						M_SB, M_SB_IAC: ;
						default: begin
							if (byte_s1 != C_IAC && byte_s1 != C_BEL) begin
								job.segs[SEG_DATA] = 1'b1;
								job.data = byte_s1;
							end
						end
					endcase
				end
				REQ_OPEN: begin
					job.segs[SEG_OPT] = 1'b1;
					job.verb = C_WILL;
					job.opt  = O_CHARSET;
				end
				REQ_RESET: begin
					clr_all = 1'b1;
					naws_le_d = 1'b0;
					job.segs[SEG_ECHO] = 1'b1;
					job.echo_val = 1'b1;
				end
				REQ_RESIZE: begin
					cols_d = wcols_s1;
					rows_d = wrows_s1;
					job.cols = wcols_s1;
					job.rows = wrows_s1;
					job.segs[SEG_NAWS] = naws_le_q;
				end
				default: ;
			endcase
		end
	end

	assign job_push = valid_s1 && (job.segs != '0);
	assign move     = valid_s1 && ((job.segs == '0) || !q_full);
	assign full     = valid_s1 && !move;
	assign accept   = push && !full;

	// option maps: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (move && ent_wr) map_q[wr_a] <= ent_d;
		if (accept) ent_s1 <= map_q[rd_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			mode_q     <= M_NORMAL;
			verb_q     <= 8'd0;
			cols_q     <= 16'd0;
			rows_q     <= 16'd0;
			naws_le_q  <= 1'b0;
			valid_s1   <= 1'b0;
			req_s1     <= REQ_BYTE;
			byte_s1    <= 8'd0;
			wcols_s1   <= 16'd0;
			wrows_s1   <= 16'd0;
			mode_s1    <= M_NORMAL;
			verb_s1    <= 8'd0;
			ent_vld_s1 <= 1'b0;
		end else begin
			mode_q <= mode_d;
			verb_q <= verb_d;
			if (move) begin
				cols_q    <= cols_d;
				rows_q    <= rows_d;
				naws_le_q <= naws_le_d;
				if (clr_all) vld_q <= '0;
				else if (ent_wr) vld_q[wr_a] <= 1'b1;
			end
			if (accept) begin
				valid_s1   <= 1'b1;
				req_s1     <= req_type;
				byte_s1    <= rx_byte;
				wcols_s1   <= win_cols;
				wrows_s1   <= win_rows;
				mode_s1    <= mode_q;
				verb_s1    <= verb_q;
				ent_vld_s1 <= vld_q[rd_a];
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

### hdl/tnrx_jobq.sv
`timescale 1ns / 1ps
module tnrx_jobq #(
	parameter int DEPTH = tnrx_pkg::JOBQ_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  tnrx_pkg::job_t wr_job,
	input  logic           rd,
	output logic           full,
	output logic           avail,
	output tnrx_pkg::job_t head
);
	import tnrx_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && avail;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CW'(do_wr) - CW'(do_rd);
		end
	end

endmodule

### hdl/tnrx_back.sv
`timescale 1ns / 1ps
module tnrx_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_avail,
	input  tnrx_pkg::job_t q_head,
	output logic           q_pop,
	input  logic           pop,
	output logic           empty,
	output logic [1:0]     out_kind,
	output logic [7:0]     out_byte,
	output logic           echo_local,
	output logic           last
);
	import tnrx_pkg::*;

	job_t cur_q, work, nxt;
	logic [5:0] idx_q, widx, nidx;
	logic cur_valid_q, wvalid, adv, seg_end, w_last;
	logic [SEG_N-1:0] low, rest;
	logic [1:0] w_kind;
	logic [7:0] w_byte;
	logic w_echo;
	logic out_valid_q;

	assign work   = cur_valid_q ? cur_q : q_head;
	assign widx   = cur_valid_q ? idx_q : 6'd0;
	assign wvalid = cur_valid_q || q_avail;
	assign low    = work.segs & (~work.segs + 1'b1);
	assign rest   = work.segs & ~low;

	always_comb begin
		w_kind = KIND_SEND;
		w_byte = 8'd0;
		w_echo = 1'b0;
		seg_end = 1'b1;
		nidx = widx + 1'b1;
		unique case (1'b1)
			low[SEG_DATA]: begin
				w_kind = KIND_DATA;
				w_byte = work.data;
			end
			low[SEG_OPT]: begin
				w_byte = (widx == 6'd0) ? C_IAC : (widx == 6'd1) ? work.verb : work.opt;
				seg_end = (widx == OPT_LAST);
			end
			low[SEG_ECHO]: begin
				w_kind = KIND_ECHO;
				w_echo = work.echo_val;
			end
			low[SEG_AYT]: begin
				w_byte = ayt_char(widx);
				seg_end = (widx == AYT_LAST);
			end
			low[SEG_GA]: begin
				w_kind = KIND_GA;
			end
			low[SEG_NAWS]: begin
				w_byte = naws_byte(widx, work.cols, work.rows);
				seg_end = (widx == NAWS_LAST);
				// size bytes sit at odd slots 3..9; skip the doubling slot unless IAC
				if (widx >= 6'd3 && widx <= 6'd9 && widx[0] && w_byte != C_IAC)
					nidx = widx + 6'd2;
			end
			default: ;
		endcase
		w_last = seg_end && (rest == '0);
		nxt = work;
		if (seg_end) begin
			nxt.segs = rest;
			nidx = 6'd0;
		end
	end

	assign adv   = wvalid && (!out_valid_q || pop);
	assign q_pop = adv && !cur_valid_q;
	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) cur_valid_q <= !w_last;
			if (adv) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cur_q      <= nxt;
			idx_q      <= nidx;
			out_kind   <= w_kind;
			out_byte   <= w_byte;
			echo_local <= w_echo;
			last       <= w_last;
		end
	end

endmodule

### hdl/telnet_rx_deframer_negotiator.sv
`timescale 1ns / 1ps
// Channel  | Handshake            | Word
// ---------+----------------------+-------------------------------------------
// input    | push / full          | req_type, rx_byte, win_cols, win_rows
// result   | pop / empty          | out_kind, out_byte, echo_local, last
//
// Flow: one input word per cycle while full is low. The map is read at accept
// and its entry registered with the word; the job enters the queue from that
// stage and the back end registers each result word, one per cycle while pop
// is high (AYT 35 words, NAWS report 9-13, DO NAWS up to 16).
// Reset: arst_n clears parser state, map valid bits, saved size and queues;
// a session reset clears all OPTION_COUNT map valid bits (256 by default).
// Stalls: full rises when the front stage holds a job the full queue cannot
// take; results hold while pop is low.
module telnet_rx_deframer_negotiator #(
	parameter int OPTION_COUNT = tnrx_pkg::OPTION_COUNT_DEF,
	parameter int JOBQ_DEPTH   = tnrx_pkg::JOBQ_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] win_cols,
	input  logic [15:0] win_rows,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic        echo_local,
	output logic        last
);
	import tnrx_pkg::*;

	logic job_push, q_full, q_avail, q_pop;
	job_t job, q_head;

	// front stage holds a word that carries a job while the job queue is full
	tnrx_front #(.OPTION_COUNT(OPTION_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .rx_byte(rx_byte),
		.win_cols(win_cols), .win_rows(win_rows),
		.q_full(q_full), .job_push(job_push), .job(job)
	);

	// decouples classification from reply expansion
	tnrx_jobq #(.DEPTH(JOBQ_DEPTH)) u_jobq (
		.clk(clk), .arst_n(arst_n), .wr(job_push), .wr_job(job),
		.rd(q_pop), .full(q_full), .avail(q_avail), .head(q_head)
	);

	// back end works from the queue head directly, so one-word jobs stream
	tnrx_back u_back (
		.clk(clk), .arst_n(arst_n), .q_avail(q_avail), .q_head(q_head),
		.q_pop(q_pop), .pop(pop), .empty(empty), .out_kind(out_kind),
		.out_byte(out_byte), .echo_local(echo_local), .last(last)
	);

endmodule

### hdl/tnrx_checker.sv
`timescale 1ns / 1ps
module tnrx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic       echo_local,
	input logic       last
);
	import tnrx_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_kind) && $stable(out_byte) && $stable(last))
		else $error("result word changed while stalled");

	a_echo_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_kind != KIND_ECHO |-> !echo_local)
		else $error("echo flag outside echo change");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_kind != KIND_SEND |-> last)
		else $error("single-word result not marked last");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (out_kind == KIND_GA || out_kind == KIND_ECHO) |-> out_byte == 8'd0)
		else $error("marker word carries a byte");

endmodule

bind telnet_rx_deframer_negotiator tnrx_checker u_tnrx_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .out_kind(out_kind),
	.out_byte(out_byte), .echo_local(echo_local), .last(last)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import tnrx_pkg::*;

	// Parser modes of the predictor
	typedef enum logic [2:0] {
		PM_NORMAL, PM_IAC, PM_VERB, PM_SB, PM_SB_IAC
	} parse_mode_t;

	// One result word as the block should deliver it
	typedef struct {
		logic [1:0] kind;
		logic [7:0] data;
		logic       echo;
		logic       last;
	} reply_word_t;

	localparam int IDLE_LIMIT = 5000;  // cycles with no handshake on either side
	localparam int SETTLE_CYC = 40;    // extra cycles once the queue drains

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  req_type;
	logic [7:0]  rx_byte;
	logic [15:0] win_cols;
	logic [15:0] win_rows;
	logic        pop;
	logic        empty;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic        echo_local;
	logic        last;

	telnet_rx_deframer_negotiator u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.req_type(req_type), .rx_byte(rx_byte), .win_cols(win_cols), .win_rows(win_rows),
		.pop(pop), .empty(empty),
		.out_kind(out_kind), .out_byte(out_byte), .echo_local(echo_local), .last(last)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// ---------------------------------------------------------------
	// Predictor state: option maps, parser, saved window size
	// ---------------------------------------------------------------
	bit [255:0]   loc_en, rem_en, loc_ann, rem_ann;
	parse_mode_t  pmode;
	logic [7:0]   verb_held;
	logic [15:0]  size_cols, size_rows;
	reply_word_t  reply_q[$];
	string        ayt_reply = "I'm here! Please be more patient!\015\012";

	int  fail_count;
	int  items_sent;
	int  words_checked;
	int  pop_hold;
	bit  calm;            // when set, neither side idles

	task automatic put_word(input logic [1:0] k, input logic [7:0] b, input logic e);
		reply_word_t w;
		w.kind = k; w.data = b; w.echo = e; w.last = 1'b0;
		reply_q.push_back(w);
	endtask

	task automatic put_send(input logic [7:0] b);
		put_word(KIND_SEND, b, 1'b0);
	endtask

	task automatic put_opt(input logic [7:0] v, input logic [7:0] o);
		put_send(C_IAC); put_send(v); put_send(o);
	endtask

	task automatic put_esc(input logic [7:0] b);
		put_send(b);
		if (b == C_IAC) put_send(b);
	endtask

	// Size report goes out only while NAWS is enabled on our side
	task automatic put_size_report();
		if (loc_en[O_NAWS]) begin
			put_send(C_IAC); put_send(C_SB); put_send(O_NAWS);
			put_esc(size_cols[15:8]); put_esc(size_cols[7:0]);
			put_esc(size_rows[15:8]); put_esc(size_rows[7:0]);
			put_send(C_IAC); put_send(C_SE);
		end
	endtask

	function automatic bit peer_ok(input logic [7:0] o);
		return o == O_SGA || o == O_STATUS || o == O_TTYPE || o == O_NAWS ||
			o == O_ECHO || o == O_CHARSET;
	endfunction

	task automatic answer_option(input logic [7:0] v, input logic [7:0] o);
		bit ours_ok;
		ours_ok = peer_ok(o) && o != O_ECHO;
		if (v == C_WILL) begin
			rem_ann[o] = 1'b1;
			if (!rem_en[o]) begin
				if (peer_ok(o)) begin
					put_opt(C_DO, o);
					rem_en[o] = 1'b1;
					if (o == O_ECHO) put_word(KIND_ECHO, 8'd0, 1'b0);
				end else
					put_opt(C_DONT, o);
			end
		end else if (v == C_WONT) begin
			if (rem_en[o] || !rem_ann[o]) begin
				put_opt(C_DONT, o);
				rem_en[o] = 1'b0;
				if (o == O_ECHO) put_word(KIND_ECHO, 8'd0, 1'b1);
			end
			rem_ann[o] = 1'b1;
		end else if (v == C_DO) begin
			if (o == O_TM)
				put_opt(C_WILL, o);
			else if (!loc_en[o]) begin
				if (ours_ok) begin
					put_opt(C_WILL, o);
					loc_en[o] = 1'b1;
				end else
					put_opt(C_WONT, o);
				loc_ann[o] = 1'b1;
			end
			if (o == O_NAWS) put_size_report();
		end else if (v == C_DONT) begin
			if (loc_en[o] || !loc_ann[o]) begin
				put_opt(C_WONT, o);
				loc_ann[o] = 1'b1;
			end
			loc_en[o] = 1'b0;
		end
	endtask

	task automatic parse_rx(input logic [7:0] c);
		case (pmode)
			PM_IAC: begin
				if (c == C_IAC) begin
					pmode = PM_NORMAL;
					put_word(KIND_DATA, c, 1'b0);
				end else if (c == C_WILL || c == C_WONT || c == C_DO || c == C_DONT) begin
					verb_held = c;
					pmode = PM_VERB;
				end else if (c == C_SB)
					pmode = PM_SB;
				else begin
					pmode = PM_NORMAL;
					if (c == C_AYT) begin
						for (int i = 0; i < ayt_reply.len(); i++)
							put_send(ayt_reply[i]);
					end else if (c == C_GA)
						put_word(KIND_GA, 8'd0, 1'b0);
				end
			end
			PM_VERB: begin
				pmode = PM_NORMAL;
				answer_option(verb_held, c);
			end
			PM_SB: if (c == C_IAC) pmode = PM_SB_IAC;
			PM_SB_IAC: pmode = (c == C_SE) ? PM_NORMAL : PM_SB;
			default: begin
				pmode = PM_NORMAL;
				if (c == C_IAC) pmode = PM_IAC;
				else if (c != C_BEL) put_word(KIND_DATA, c, 1'b0);
			end
		endcase
	endtask

	task automatic clear_session();
		loc_en = '0; rem_en = '0; loc_ann = '0; rem_ann = '0;
		pmode = PM_NORMAL;
		verb_held = 8'd0;
	endtask

	// Work out every word one accepted item should yield
	task automatic predict_replies(input logic [1:0] rq, input logic [7:0] b,
		input logic [15:0] c, input logic [15:0] r);
		int before_n;
		before_n = reply_q.size();
		case (rq)
			REQ_BYTE:  parse_rx(b);
			REQ_OPEN:  put_opt(C_WILL, O_CHARSET);
			REQ_RESET: begin
				clear_session();
				put_word(KIND_ECHO, 8'd0, 1'b1);
			end
			default: begin
				size_cols = c;
				size_rows = r;
				put_size_report();
			end
		endcase
		if (reply_q.size() > before_n)
			reply_q[reply_q.size() - 1].last = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// Sender: one word per call, gap drawn before it
	// ---------------------------------------------------------------
	task automatic send_word(input logic [1:0] rq, input logic [7:0] b,
		input logic [15:0] c, input logic [15:0] r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push     <= 1'b1;
		req_type <= rq;
		rx_byte  <= b;
		win_cols <= c;
		win_rows <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_replies(rq, b, c, r);
		items_sent++;
	endtask

	task automatic send_rx(input logic [7:0] b);
		send_word(REQ_BYTE, b, 16'($urandom), 16'($urandom));
	endtask

	task automatic send_cmd(input logic [7:0] v, input logic [7:0] o);
		send_rx(C_IAC); send_rx(v); send_rx(o);
	endtask

	task automatic send_resize(input logic [15:0] c, input logic [15:0] r);
		send_word(REQ_RESIZE, 8'($urandom), c, r);
	endtask

	// Pause the sender until every outstanding word is back
	task automatic drain_replies();
		@(negedge clk) push <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Result side: random pop stalls, compare against oldest word
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else
			pop <= 1'b1;
	end

	always @(posedge clk) begin
		reply_word_t w;
		if (arst_n && pop && !empty) begin
			if (reply_q.size() == 0) begin
				$error("unexpected word: kind %0d byte %0d echo %0d last %0d",
					out_kind, out_byte, echo_local, last);
				fail_count++;
			end else begin
				w = reply_q.pop_front();
				if (out_kind !== w.kind) begin
					$error("out_kind: expected %0d, actual %0d", w.kind, out_kind);
					fail_count++;
				end
				if (out_byte !== w.data) begin
					$error("out_byte: expected %0d, actual %0d", w.data, out_byte);
					fail_count++;
				end
				if (echo_local !== w.echo) begin
					$error("echo_local: expected %0d, actual %0d", w.echo, echo_local);
					fail_count++;
				end
				if (last !== w.last) begin
					$error("last: expected %0d, actual %0d", w.last, last);
					fail_count++;
				end
			end
			words_checked++;
			pop_hold = calm ? 0 : $urandom_range(0, 10);
			if ($urandom_range(0, 3) == 0) pop_hold = 0;
		end
	end

	// Watchdog: any handshake on either side resets the count
	int idle_cyc;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("timeout: %0d words still outstanding", reply_q.size());
			$display("telnet_rx_deframer_negotiator regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_negotiation();
		send_word(REQ_OPEN, 8'd0, 16'd0, 16'd0);
		send_cmd(C_WILL, O_ECHO);       // echo handed to the server
		send_cmd(C_WILL, O_ECHO);       // already on: silent
		send_cmd(C_WONT, O_ECHO);       // back to local echo
		send_cmd(C_WONT, 8'd200);       // never announced: still answered
		send_cmd(C_WILL, 8'd99);        // unsupported remote
		send_cmd(C_DO, 8'd99);          // unsupported local
		send_cmd(C_DO, O_TM);           // timing mark always answered
		send_cmd(C_DO, O_TM);
		send_cmd(C_DONT, 8'd255);
		send_cmd(C_DONT, 8'd0);
	endtask

	task automatic test_window_size();
		send_resize(16'hFFFF, 16'hFFFF);  // NAWS off: nothing sent
		send_cmd(C_DO, O_NAWS);           // enable plus report with doubled IACs
		send_resize(16'h0000, 16'h0000);
		send_resize(16'h00FF, 16'hFF00);
		send_cmd(C_DO, O_NAWS);           // already on: report only
		send_cmd(C_DONT, O_NAWS);
		send_resize(16'h1234, 16'h5678);
	endtask

	task automatic test_framing();
		send_rx(8'd0);
		send_rx(C_BEL);                   // bell dropped
		send_rx(8'd254);
		send_rx(C_IAC); send_rx(C_IAC);   // escaped 255 forwarded
		send_rx(C_IAC); send_rx(C_AYT);
		send_rx(C_IAC); send_rx(C_GA);
		send_rx(C_IAC); send_rx(C_SE);    // stray SE ignored
		send_rx(C_IAC); send_rx(8'd100);  // non-verb command ignored
		// subnegotiation body swallowed, IAC IAC stays inside
		send_rx(C_IAC); send_rx(C_SB); send_rx(8'd24);
		send_rx(C_IAC); send_rx(C_IAC); send_rx(C_AYT);
		send_rx(C_IAC); send_rx(C_GA);    // IAC non-SE returns to the body
		send_rx(C_IAC); send_rx(C_SE);
		send_rx(8'h41);
		send_word(REQ_RESET, 8'd0, 16'd0, 16'd0);
		send_resize(16'hABCD, 16'h00FF);  // maps cleared, size kept
	endtask

	function automatic logic [7:0] pick_option();
		case ($urandom_range(0, 9))
			0: return O_ECHO;
			1: return O_SGA;
			2: return O_STATUS;
			3: return O_TM;
			4: return O_TTYPE;
			5, 6: return O_NAWS;
			7: return O_CHARSET;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_size();
		case ($urandom_range(0, 4))
			0: return 16'hFFFF;
			1: return {8'hFF, 8'($urandom)};
			2: return {8'($urandom), 8'hFF};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_random(input int n_items);
		logic [7:0] verbs[4];
		int sel;
		verbs = '{C_WILL, C_WONT, C_DO, C_DONT};
		while (items_sent < n_items) begin
			if ($urandom_range(0, 15) == 0) calm = !calm;
			sel = $urandom_range(0, 99);
			if (sel < 25)
				send_rx(8'($urandom));                         // text, also noise
			else if (sel < 55)
				send_cmd(verbs[$urandom_range(0, 3)], pick_option());
			else if (sel < 65)
				send_resize(pick_size(), pick_size());
			else if (sel < 70) begin
				send_rx(C_IAC); send_rx(C_IAC);
			end else if (sel < 72) begin
				send_rx(C_IAC); send_rx(C_AYT);
			end else if (sel < 76) begin
				send_rx(C_IAC); send_rx(C_GA);
			end else if (sel < 83) begin
				send_rx(C_IAC); send_rx(C_SB);
				repeat ($urandom_range(0, 4)) send_rx(8'($urandom));
				if ($urandom_range(0, 1)) begin
					send_rx(C_IAC); send_rx(C_IAC);
				end
				send_rx(C_IAC); send_rx(C_SE);
			end else if (sel < 87) begin
				send_rx(C_IAC); send_rx(8'($urandom));         // broken sequence
			end else if (sel < 91)
				send_word(REQ_OPEN, 8'($urandom), 16'($urandom), 16'($urandom));
			else if (sel < 94)
				send_word(REQ_RESET, 8'($urandom), 16'($urandom), 16'($urandom));
			else
				send_rx(C_IAC);                                // dangling IAC
		end
		calm = 1'b0;
	endtask

	initial begin
		fail_count    = 0;
		items_sent    = 0;
		words_checked = 0;
		pop_hold      = 0;
		calm          = 1'b0;
		clear_session();
		size_cols = 16'd0;
		size_rows = 16'd0;
		arst_n   = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		req_type = REQ_BYTE;
		rx_byte  = 8'd0;
		win_cols = 16'd0;
		win_rows = 16'd0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_negotiation();
		drain_replies();
		test_window_size();
		test_framing();
		test_random(300);

		@(negedge clk) push <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		$display("covered %0d input items and %0d result words: negotiation, framing,",
			items_sent, words_checked);
		$display("window reports, AYT, GA, subnegotiation and session events");
		if (fail_count == 0)
			$display("telnet_rx_deframer_negotiator regression: pass");
		else
			$display("telnet_rx_deframer_negotiator regression: fail");
		$finish;
	end

endmodule
